>>> sv/fbv_pkg.sv
// Shared constants and control types for the frustum box visibility test.
`default_nettype none
package fbv_pkg;

  localparam int unsigned REG_WIDTH   = 64;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned PLANE_COUNT = 6;
  localparam int unsigned AXIS_COUNT  = 3;
  localparam int unsigned COORD_FRAC  = 4;
  localparam int unsigned MAT_FRAC    = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_COL_0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_COL_1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_COL_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_COL_3 = 2'd3;

  // Load strobe for the product stage
  typedef struct packed {
    logic ld_prod;
  } fbv_ctrl_t;

endpackage
`default_nettype wire

>>> sv/frustum_box_visibility_test.sv
// Frustum visibility test for axis-aligned boxes: top level.
// Usage:
//  - Configure the view-projection matrix column by column on the write port
//    (cfg_idx_i 0..3 = matrix_col_0..3) while no request is in flight.
//    Reset loads the identity matrix.
//  - Each box arrives as one request on s_axis; the answer (visible, bit 0 of
//    m_axis_tdata) leaves on m_axis, one answer per box, in order.
//  - Path: an answer passes the input register (loaded at the accepting edge),
//    then the product register, then the result register.
//  - Throughput: one box per cycle while the receiver takes answers; the three
//    stages advance independently, so a stalled receiver only stops stages that
//    hold data, and the block keeps taking requests until every stage is full.
//  - Reset empties the pipeline; no answer is pending after reset.
//  - Per plane: three signed multiplies into registers, then one four-term
//    add whose sign rejects the box; a plane with an all-zero normal never
//    rejects.
`default_nettype none
module frustum_box_visibility_test #(
  parameter int unsigned COORD_WIDTH  = 16,
  parameter int unsigned MATRIX_WIDTH = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   cfg_we_i,
  input  wire logic [fbv_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  wire logic [fbv_pkg::REG_WIDTH-1:0]          cfg_wdata_i,
  input  wire logic                                   s_axis_tvalid,
  output logic                                        s_axis_tready,
  // min_x, min_y, min_z, max_x, max_y, max_z, zero pad
  input  wire logic [((6*COORD_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
  output logic                                        m_axis_tvalid,
  input  wire logic                                   m_axis_tready,
  // visible, zero pad
  output logic [7:0]                                  m_axis_tdata
);
  import fbv_pkg::*;

  logic signed [COORD_WIDTH-1:0]  lo_q [AXIS_COUNT];
  logic signed [COORD_WIDTH-1:0]  hi_q [AXIS_COUNT];
  logic                           box_vld_q, prod_vld_q, out_vld_q;
  logic                           ld_box, ld_prod, ld_out;
  fbv_ctrl_t                      ctrl;
  logic signed [MATRIX_WIDTH:0]   plane_n [PLANE_COUNT][AXIS_COUNT];
  logic signed [MATRIX_WIDTH:0]   plane_d [PLANE_COUNT];
  logic [PLANE_COUNT-1:0]         plane_skip;
  logic [PLANE_COUNT-1:0]         reject;
  logic                           visible_d, visible_q;

  // A stage loads when empty or when its contents move on
  assign ld_out  = !out_vld_q || m_axis_tready;
  assign ld_prod = !prod_vld_q || ld_out;
  assign ld_box  = !box_vld_q || ld_prod;
  assign s_axis_tready = ld_box;

  assign ctrl.ld_prod = ld_prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_vld_q  <= 1'b0;
      prod_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (ld_box)  box_vld_q  <= s_axis_tvalid;
      if (ld_prod) prod_vld_q <= box_vld_q;
      if (ld_out)  out_vld_q  <= prod_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_box && s_axis_tvalid) begin
      for (int c = 0; c < AXIS_COUNT; c++) begin
        lo_q[c] <= signed'(s_axis_tdata[c*COORD_WIDTH +: COORD_WIDTH]);
        hi_q[c] <= signed'(s_axis_tdata[(c+AXIS_COUNT)*COORD_WIDTH +: COORD_WIDTH]);
      end
    end
  end

  fbv_cfg_regs #(
    .MATRIX_WIDTH (MATRIX_WIDTH)
  ) u_cfg_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .plane_n_o    (plane_n),
    .plane_d_o    (plane_d),
    .plane_skip_o (plane_skip)
  );

  for (genvar k = 0; k < PLANE_COUNT; k++) begin : g_plane
    fbv_plane_test #(
      .COORD_WIDTH  (COORD_WIDTH),
      .MATRIX_WIDTH (MATRIX_WIDTH)
    ) u_plane (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .n_i      (plane_n[k]),
      .d_i      (plane_d[k]),
      .skip_i   (plane_skip[k]),
      .lo_i     (lo_q),
      .hi_i     (hi_q),
      .reject_o (reject[k])
    );
  end

  assign visible_d = ~|reject;

  always_ff @(posedge clk_i) begin
    if (ld_out) visible_q <= visible_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'b0, visible_q};

endmodule
`default_nettype wire

>>> sv/fbv_cfg_regs.sv
// Matrix registers and derivation of the six clip planes.
`default_nettype none
module fbv_cfg_regs #(
  parameter int unsigned MATRIX_WIDTH = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [fbv_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [fbv_pkg::REG_WIDTH-1:0]   cfg_wdata_i,
  output logic signed [MATRIX_WIDTH:0]         plane_n_o [fbv_pkg::PLANE_COUNT][fbv_pkg::AXIS_COUNT],
  output logic signed [MATRIX_WIDTH:0]         plane_d_o [fbv_pkg::PLANE_COUNT],
  output logic        [fbv_pkg::PLANE_COUNT-1:0] plane_skip_o
);
  import fbv_pkg::*;

  localparam int unsigned EXT_W = (4 * MATRIX_WIDTH > REG_WIDTH) ? 4 * MATRIX_WIDTH : REG_WIDTH;

  localparam logic [REG_WIDTH-1:0] RST_COL_0 = REG_WIDTH'(1) << MAT_FRAC;
  localparam logic [REG_WIDTH-1:0] RST_COL_1 =
    (MAT_FRAC + MATRIX_WIDTH < REG_WIDTH) ? REG_WIDTH'(1) << (MAT_FRAC + MATRIX_WIDTH) : '0;
  localparam logic [REG_WIDTH-1:0] RST_COL_2 =
    (MAT_FRAC + 2 * MATRIX_WIDTH < REG_WIDTH) ? REG_WIDTH'(1) << (MAT_FRAC + 2 * MATRIX_WIDTH) : '0;
  localparam logic [REG_WIDTH-1:0] RST_COL_3 =
    (MAT_FRAC + 3 * MATRIX_WIDTH < REG_WIDTH) ? REG_WIDTH'(1) << (MAT_FRAC + 3 * MATRIX_WIDTH) : '0;

  logic [REG_WIDTH-1:0] col_q [4];
  logic [EXT_W-1:0]     col_ext [4];
  logic signed [MATRIX_WIDTH-1:0] ent [4][4];   // [column][row]

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q[0] <= RST_COL_0;
      col_q[1] <= RST_COL_1;
      col_q[2] <= RST_COL_2;
      col_q[3] <= RST_COL_3;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MATRIX_COL_0: col_q[0] <= cfg_wdata_i;
        CFG_MATRIX_COL_1: col_q[1] <= cfg_wdata_i;
        CFG_MATRIX_COL_2: col_q[2] <= cfg_wdata_i;
        CFG_MATRIX_COL_3: col_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Rows lying past bit 63 read as zero
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      col_ext[c] = EXT_W'(col_q[c]);
      for (int r = 0; r < 4; r++) begin
        ent[c][r] = signed'(col_ext[c][r*MATRIX_WIDTH +: MATRIX_WIDTH]);
      end
    end
  end

  // Plane k: row 3 plus row k/2 for even k, minus for odd k
  always_comb begin
    for (int k = 0; k < PLANE_COUNT; k++) begin
      for (int c = 0; c < AXIS_COUNT; c++) begin
        if (k % 2 == 1) begin
          plane_n_o[k][c] = (MATRIX_WIDTH+1)'(ent[c][3]) - (MATRIX_WIDTH+1)'(ent[c][k/2]);
        end else begin
          plane_n_o[k][c] = (MATRIX_WIDTH+1)'(ent[c][3]) + (MATRIX_WIDTH+1)'(ent[c][k/2]);
        end
      end
      if (k % 2 == 1) begin
        plane_d_o[k] = (MATRIX_WIDTH+1)'(ent[3][3]) - (MATRIX_WIDTH+1)'(ent[3][k/2]);
      end else begin
        plane_d_o[k] = (MATRIX_WIDTH+1)'(ent[3][3]) + (MATRIX_WIDTH+1)'(ent[3][k/2]);
      end
      plane_skip_o[k] = (plane_n_o[k][0] == '0) && (plane_n_o[k][1] == '0)
                        && (plane_n_o[k][2] == '0);
    end
  end

endmodule
`default_nettype wire

>>> sv/fbv_plane_test.sv
// One clip plane: positive-vertex products, then signed distance and reject.
`default_nettype none
module fbv_plane_test #(
  parameter int unsigned COORD_WIDTH  = 16,
  parameter int unsigned MATRIX_WIDTH = 16
) (
  input  wire logic                            clk_i,
  input  wire fbv_pkg::fbv_ctrl_t              ctrl_i,
  input  wire logic signed [MATRIX_WIDTH:0]    n_i [fbv_pkg::AXIS_COUNT],
  input  wire logic signed [MATRIX_WIDTH:0]    d_i,
  input  wire logic                            skip_i,
  input  wire logic signed [COORD_WIDTH-1:0]   lo_i [fbv_pkg::AXIS_COUNT],
  input  wire logic signed [COORD_WIDTH-1:0]   hi_i [fbv_pkg::AXIS_COUNT],
  output logic                                 reject_o
);
  import fbv_pkg::*;

  localparam int unsigned PROD_W = MATRIX_WIDTH + 1 + COORD_WIDTH;
  localparam int unsigned ACC_W  = PROD_W + 2;

  logic signed [PROD_W-1:0]      prod_d [AXIS_COUNT];
  logic signed [PROD_W-1:0]      prod_q [AXIS_COUNT];
  logic signed [MATRIX_WIDTH:0]  d_q;
  logic                          skip_q;
  logic signed [ACC_W-1:0]       acc;

  // Corner farthest along the normal: max on a non-negative component
  always_comb begin
    for (int c = 0; c < AXIS_COUNT; c++) begin
      prod_d[c] = PROD_W'(n_i[c]) * PROD_W'(n_i[c][MATRIX_WIDTH] ? lo_i[c] : hi_i[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_prod) begin
      prod_q <= prod_d;
      d_q    <= d_i;
      skip_q <= skip_i;
    end
  end

  always_comb begin
    acc = (ACC_W'(d_q) <<< COORD_FRAC) + ACC_W'(prod_q[0]) + ACC_W'(prod_q[1])
          + ACC_W'(prod_q[2]);
  end

  assign reject_o = !skip_q && acc[ACC_W-1];

endmodule
`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for the frustum box visibility test block.
`timescale 1ns / 100ps

module testbench;
  import fbv_pkg::*;

  localparam int COORD_W        = 16;
  localparam int MAT_W          = 16;
  localparam int TDATA_W        = ((6 * COORD_W + 7) / 8) * 8;
  localparam int PIPE_LATENCY   = 3;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] min_z;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] max_y;
    logic signed [COORD_W-1:0] max_z;
  } box_t;

  typedef struct {
    box_t box;
    logic visible;
  } verdict_t;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_MOSTLY} rx_mode_e;
  typedef enum int {COL_SMALL, COL_SPARSE, COL_FULL} col_style_e;

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_idx_i     = CFG_MATRIX_COL_0;
  logic [REG_WIDTH-1:0]     cfg_wdata_i   = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [TDATA_W-1:0]       s_axis_tdata  = '0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [7:0]               m_axis_tdata;

  // local copy of the matrix registers
  logic [REG_WIDTH-1:0] matrix_col [4];
  verdict_t             pending_verdicts [$];

  int       burst_left      = 0;
  int       gap_max         = 3;
  rx_mode_e rx_mode         = RX_MOSTLY;
  int       hold_request    = 0;
  int       hold_left       = 0;
  int       cycle_count     = 0;
  int       idle_cycles     = 0;
  int       mismatch_count  = 0;
  int       boxes_sent      = 0;
  int       visible_seen    = 0;
  int       culled_seen     = 0;
  int       matrix_settings = 0;

  frustum_box_visibility_test #(
    .COORD_WIDTH  (COORD_W),
    .MATRIX_WIDTH (MAT_W)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  function automatic longint matrix_entry(int col, int row);
    logic signed [MAT_W-1:0] e;
    e = matrix_col[col][row*MAT_W +: MAT_W];
    return longint'(e);
  endfunction

  // Plane k: row 3 plus (even k) or minus (odd k) row k/2; p-vertex picked per axis
  function automatic logic box_in_frustum(box_t b);
    longint lo [3];
    longint hi [3];
    longint n [3];
    longint plane_dist;
    longint acc;
    int     axis;
    bit     minus;
    bit     zero_normal;
    lo[0] = b.min_x; lo[1] = b.min_y; lo[2] = b.min_z;
    hi[0] = b.max_x; hi[1] = b.max_y; hi[2] = b.max_z;
    for (int k = 0; k < PLANE_COUNT; k++) begin
      axis = k / 2;
      minus = (k % 2) == 1;
      zero_normal = 1'b1;
      for (int c = 0; c < AXIS_COUNT; c++) begin
        n[c] = minus ? matrix_entry(c, 3) - matrix_entry(c, axis)
                     : matrix_entry(c, 3) + matrix_entry(c, axis);
        if (n[c] != 0) zero_normal = 1'b0;
      end
      if (zero_normal) continue;
      plane_dist = minus ? matrix_entry(3, 3) - matrix_entry(3, axis)
                         : matrix_entry(3, 3) + matrix_entry(3, axis);
      acc = plane_dist * (longint'(1) << COORD_FRAC);
      for (int c = 0; c < AXIS_COUNT; c++)
        acc += n[c] * ((n[c] >= 0) ? hi[c] : lo[c]);
      if (acc < 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic box_t make_box(int mnx, int mny, int mnz, int mxx, int mxy, int mxz);
    box_t b;
    b.min_x = COORD_W'(mnx); b.min_y = COORD_W'(mny); b.min_z = COORD_W'(mnz);
    b.max_x = COORD_W'(mxx); b.max_y = COORD_W'(mxy); b.max_z = COORD_W'(mxz);
    return b;
  endfunction

  function automatic int clamp_coord(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Mostly well-formed boxes at a random scale; a tenth are raw noise
  function automatic box_t random_box();
    int span;
    int centre;
    int half;
    int lo_c [3];
    int hi_c [3];
    box_t b;
    if ($urandom_range(0, 9) == 0) begin
      b = {$urandom, $urandom, $urandom};
      return b;
    end
    case ($urandom_range(0, 3))
      0:       span = 64;
      1:       span = 512;
      2:       span = 4096;
      default: span = 32767;
    endcase
    for (int c = 0; c < 3; c++) begin
      centre = int'($urandom_range(0, 2 * span)) - span;
      half = $urandom_range(0, span / 2);
      lo_c[c] = clamp_coord(centre - half);
      hi_c[c] = clamp_coord(centre + half);
    end
    return make_box(lo_c[0], lo_c[1], lo_c[2], hi_c[0], hi_c[1], hi_c[2]);
  endfunction

  function automatic logic [REG_WIDTH-1:0] pack_col(int r0, int r1, int r2, int r3);
    return {MAT_W'(r3), MAT_W'(r2), MAT_W'(r1), MAT_W'(r0)};
  endfunction

  function automatic logic [REG_WIDTH-1:0] random_column(col_style_e style);
    logic [REG_WIDTH-1:0] col;
    col = {$urandom, $urandom};
    if (style == COL_FULL) return col;
    for (int r = 0; r < 4; r++) begin
      if (style == COL_SMALL)
        col[r*MAT_W +: MAT_W] = MAT_W'(int'($urandom_range(0, 4096)) - 2048);
      else if ($urandom_range(0, 9) < 4)
        col[r*MAT_W +: MAT_W] = '0;
    end
    return col;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_WIDTH-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    matrix_col[idx] = value;
  endtask

  // only called with the pipeline drained
  task automatic set_matrix(input logic [REG_WIDTH-1:0] c0, c1, c2, c3);
    write_reg(CFG_MATRIX_COL_0, c0);
    write_reg(CFG_MATRIX_COL_1, c1);
    write_reg(CFG_MATRIX_COL_2, c2);
    write_reg(CFG_MATRIX_COL_3, c3);
    cfg_we_i <= 1'b0;
    matrix_settings++;
  endtask

  task automatic send_box(input box_t b);
    int gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 32);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b.max_z, b.max_y, b.max_x, b.min_z, b.min_y, b.min_x};
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    pending_verdicts.push_back('{box: b, visible: box_in_frustum(b)});
    boxes_sent++;
  endtask

  // always advances at least one edge, so tvalid never gets two updates in a step
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending_verdicts.size() != 0);
  endtask

  task automatic test_identity_frustum();
    // reset matrix: frustum is the cube [-1, 1], i.e. +-16 in coordinate units
    send_box(make_box(-16, -16, -16, 16, 16, 16));
    send_box(make_box(-100, -8, -8, -16, 8, 8));  // touches left plane: distance zero
    send_box(make_box(-100, -8, -8, -17, 8, 8));
    send_box(make_box(16, -8, -8, 100, 8, 8));
    send_box(make_box(17, -8, -8, 100, 8, 8));
    send_box(make_box(-8, 17, -8, 8, 40, 8));
    send_box(make_box(-8, -8, 17, 8, 8, 100));
    send_box(make_box(16, 16, 16, -16, -16, -16));  // min above max, used as given
    send_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768));
    send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
  endtask

  task automatic test_degenerate_planes();
    wait_drained();
    set_matrix('0, '0, '0, '0);  // every plane has a zero normal
    send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767));
    send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
    wait_drained();
    // row 3 equals row 0 in the normal columns: right plane vanishes
    set_matrix(pack_col(1024, 0, 0, 1024), pack_col(0, 1024, 0, 0),
               pack_col(0, 0, 1024, 0), pack_col(0, 0, 0, 1024));
    send_box(make_box(500, -8, -8, 600, 8, 8));
    send_box(make_box(-600, -8, -8, -500, 8, 8));
    wait_drained();
    // translation only: zero normals skip the plane despite a negative offset
    set_matrix('0, '0, '0, pack_col(-1024, 2048, 0, -2048));
    send_box(make_box(-5, -5, -5, 5, 5, 5));
  endtask

  task automatic test_extreme_entries();
    wait_drained();
    set_matrix('1, '1, '1, '1);
    send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
    send_box(make_box(32767, 32767, 32767, -32768, -32768, -32768));
    wait_drained();
    set_matrix(pack_col(-32768, 32767, -32768, 32767), pack_col(-32768, 32767, -32768, 32767),
               pack_col(-32768, 32767, -32768, 32767), pack_col(-32768, 32767, -32768, 32767));
    send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
    send_box(make_box(32767, 32767, 32767, -32768, -32768, -32768));
    wait_drained();
    set_matrix(pack_col(32767, 32767, 32767, 32767), pack_col(32767, 32767, 32767, 32767),
               pack_col(32767, 32767, 32767, 32767), pack_col(-32768, -32768, -32768, -32768));
    send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
    send_box(make_box(32767, 32767, 32767, -32768, -32768, -32768));
  endtask

  task automatic test_full_pipeline_stall();
    wait_drained();
    set_matrix(pack_col(1024, 0, 0, 0), pack_col(0, 1024, 0, 0),
               pack_col(0, 0, 1024, 0), pack_col(0, 0, 0, 1024));
    gap_max = 0;
    rx_mode = RX_ALWAYS;
    hold_request = 400;
    repeat (120) send_box(random_box());
    wait_drained();
  endtask

  task automatic test_random_scenes();
    int sx;
    int sy;
    for (int phase = 0; phase < 12; phase++) begin
      wait_drained();
      case (phase % 4)
        0: begin
          // perspective-like: w = -z, random focal scales and depth mapping
          sx = $urandom_range(256, 3000);
          sy = $urandom_range(256, 3000);
          set_matrix(pack_col(sx, 0, 0, 0), pack_col(0, sy, 0, 0),
                     pack_col(0, 0, -int'($urandom_range(1024, 1500)), -1024),
                     pack_col(int'($urandom_range(0, 512)) - 256,
                              int'($urandom_range(0, 512)) - 256,
                              -int'($urandom_range(100, 4000)), 0));
        end
        1: set_matrix(random_column(COL_SMALL), random_column(COL_SMALL),
                      random_column(COL_SMALL), random_column(COL_SMALL));
        2: set_matrix(random_column(COL_SPARSE), random_column(COL_SPARSE),
                      random_column(COL_SPARSE), random_column(COL_SPARSE));
        default: set_matrix(random_column(COL_FULL), random_column(COL_FULL),
                            random_column(COL_FULL), random_column(COL_FULL));
      endcase
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      gap_max = (phase % 3 == 0) ? 0 : $urandom_range(1, 12);
      repeat ($urandom_range(90, 130)) send_box(random_box());
    end
  endtask

  initial begin
    matrix_col[0] = 64'd1 << MAT_FRAC;
    matrix_col[1] = 64'd1 << (MAT_FRAC + MAT_W);
    matrix_col[2] = 64'd1 << (MAT_FRAC + 2 * MAT_W);
    matrix_col[3] = 64'd1 << (MAT_FRAC + 3 * MAT_W);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_identity_frustum();
    test_degenerate_planes();
    test_extreme_entries();
    test_full_pipeline_stall();
    test_random_scenes();
    wait_drained();
    repeat (PIPE_LATENCY + 5) @(posedge clk_i);
    $display("Ran %0d boxes (%0d visible, %0d culled) across %0d matrix settings,",
             boxes_sent, visible_seen, culled_seen, matrix_settings + 1);
    $display("with sender gaps, receiver stalls and a long output hold-off.");
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // receiver: stall pattern per phase, plus a counted hold-off on request
  always @(posedge clk_i) begin
    cycle_count++;
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS:   m_axis_tready <= 1'b1;
        RX_RANDOM:   m_axis_tready <= ($urandom_range(0, 1) == 1);
        RX_PERIODIC: m_axis_tready <= (cycle_count % 11) < 6;
        default:     m_axis_tready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("answer with no box outstanding");
      end else begin
        want = pending_verdicts.pop_front();
        if (m_axis_tdata[0] !== want.visible) begin
          report_mismatch($sformatf("box min (%0d,%0d,%0d) max (%0d,%0d,%0d): visible %b, want %b",
                                    want.box.min_x, want.box.min_y, want.box.min_z,
                                    want.box.max_x, want.box.max_y, want.box.max_z,
                                    m_axis_tdata[0], want.visible));
        end else if (want.visible) begin
          visible_seen++;
        end else begin
          culled_seen++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule
